/* sv/adc_channel_scan_sequencer_core_assert.svh */
// assertion macros used by the adc channel scan sequencer checker
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("acss check failed");

// next-cycle implication, checked outside reset
`define ACSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("acss check failed");

`endif

/* sv/acss_pkg.sv */
// shared types and constants of the adc channel scan sequencer
package acss_pkg;

    localparam int ChannelCount = 6;
    localparam int ChanW        = 3;
    localparam int CntW         = ChanW + 1;
    localparam int EnableBits   = 6;
    localparam int SettleW      = 8;
    localparam int ByteW        = 8;
    localparam int ValueW       = 16;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 8;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgEnableMask  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSettleTicks = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEightBit    = 2'd2;

    // reset values of the configuration registers
    localparam logic [EnableBits-1:0] EnableMaskReset  = 6'h3f;
    localparam logic [SettleW-1:0]    SettleTicksReset = 8'd10;

    typedef enum logic [2:0] {
        STEP_INIT     = 3'd0,
        STEP_SAMPLING = 3'd1,
        STEP_CONFIG   = 3'd2,
        STEP_WAIT     = 3'd3,
        STEP_READ     = 3'd4
    } scan_step_t;

    typedef struct packed {
        logic [EnableBits-1:0] channel_enable_mask;
        logic [SettleW-1:0]    settle_ticks;
        logic                  eight_bit_mode;
    } acss_cfg_t;

    // what one tick of the scan produces
    typedef struct packed {
        logic             start_conversion;
        logic [ChanW-1:0] mux_select;
        logic             write;
        logic [ChanW-1:0] channel;
    } acss_tick_t;

endpackage

/* sv/adc_channel_scan_sequencer_core.sv */
// Round-robin ADC channel scan sequencer. Each s_ word is one scheduler tick and
// yields exactly one m_ word. A tick is taken into an input register, runs through
// the scan state machine and the per-channel result store in one pass, and lands in
// an output register, from which its word shows on the m_ ports; one tick per clock is
// sustained while m_ready is high. Configuration writes go through the cfg_ channel, are
// always taken, and must only be issued while no tick is in flight.
module adc_channel_scan_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acss_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [acss_pkg::CfgDataW-1:0]   cfg_data,
    // tick input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_converter_busy,
    input  logic [acss_pkg::ByteW-1:0]      s_result_low_byte,
    input  logic [acss_pkg::ByteW-1:0]      s_result_high_byte,
    input  logic [acss_pkg::ChanW-1:0]      s_query_channel,
    // tick result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_start_conversion,
    output logic [acss_pkg::ChanW-1:0]      m_mux_select,
    output logic                            m_sample_stored,
    output logic [acss_pkg::ValueW-1:0]     m_query_value
);

    acss_pkg::acss_cfg_t            cfg_reg;
    acss_pkg::acss_tick_t           tick;
    logic                           in_valid_reg;
    logic                           busy_reg;
    logic [acss_pkg::ByteW-1:0]     low_reg;
    logic [acss_pkg::ByteW-1:0]     high_reg;
    logic [acss_pkg::ChanW-1:0]     query_reg;
    logic                           out_valid_reg;
    logic                           start_reg;
    logic [acss_pkg::ChanW-1:0]     mux_reg;
    logic                           stored_reg;
    logic [acss_pkg::ValueW-1:0]    qval_reg;
    logic [acss_pkg::ValueW-1:0]    query_value;
    logic                           advance;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_enable_mask <= acss_pkg::EnableMaskReset;
            cfg_reg.settle_ticks        <= acss_pkg::SettleTicksReset;
            cfg_reg.eight_bit_mode      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                acss_pkg::CfgEnableMask:
                    cfg_reg.channel_enable_mask <= cfg_data[acss_pkg::EnableBits-1:0];
                acss_pkg::CfgSettleTicks:
                    cfg_reg.settle_ticks <= cfg_data[acss_pkg::SettleW-1:0];
                acss_pkg::CfgEightBit:
                    cfg_reg.eight_bit_mode <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow: a tick moves on when the output register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            busy_reg  <= s_converter_busy;
            low_reg   <= s_result_low_byte;
            high_reg  <= s_result_high_byte;
            query_reg <= s_query_channel;
        end
    end

    acss_scan_ctrl u_scan_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .converter_busy (busy_reg),
        .cfg            (cfg_reg),
        .tick           (tick)
    );

    acss_result_store u_result_store (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (tick),
        .eight_bit_mode   (cfg_reg.eight_bit_mode),
        .result_low_byte  (low_reg),
        .result_high_byte (high_reg),
        .query_channel    (query_reg),
        .query_value      (query_value)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            start_reg  <= tick.start_conversion;
            mux_reg    <= tick.mux_select;
            stored_reg <= tick.write;
            qval_reg   <= query_value;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_start_conversion = start_reg;
    assign m_mux_select       = mux_reg;
    assign m_sample_stored    = stored_reg;
    assign m_query_value      = qval_reg;

endmodule

/* sv/acss_scan_ctrl.sv */
// scan state machine: channel round robin, settle count and converter handshake
module acss_scan_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                converter_busy,
    input  acss_pkg::acss_cfg_t cfg,
    output acss_pkg::acss_tick_t tick
);

    acss_pkg::scan_step_t                step_reg, step_next;
    logic [acss_pkg::ChanW-1:0]          channel_reg, channel_next;
    logic [acss_pkg::SettleW-1:0]        settle_reg, settle_next;
    logic [acss_pkg::ChanW-1:0]          chan_inc;
    logic [acss_pkg::ChanW-1:0]          chan_wrap;
    logic                                chan_enabled;

    // state registers, updated once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= acss_pkg::STEP_INIT;
            channel_reg <= '0;
            settle_reg  <= '0;
        end else if (advance) begin
            step_reg    <= step_next;
            channel_reg <= channel_next;
            settle_reg  <= settle_next;
        end
    end

    // next round-robin channel and its enable bit
    always_comb begin
        chan_inc  = channel_reg + 3'd1;
        chan_wrap = ({1'b0, chan_inc} < acss_pkg::CntW'(acss_pkg::ChannelCount)) ? chan_inc : '0;
        chan_enabled = ({1'b0, chan_wrap} < acss_pkg::CntW'(acss_pkg::EnableBits))
                       && cfg.channel_enable_mask[chan_wrap];
    end

    // next state and tick outputs
    always_comb begin
        step_next             = step_reg;
        channel_next          = channel_reg;
        settle_next           = settle_reg;
        tick.start_conversion = 1'b0;
        tick.write            = 1'b0;
        tick.channel          = channel_reg;
        unique case (step_reg)
            acss_pkg::STEP_INIT: begin
                channel_next = chan_wrap;
                if (chan_enabled) begin
                    step_next   = acss_pkg::STEP_SAMPLING;
                    settle_next = cfg.settle_ticks;
                end
            end
            acss_pkg::STEP_SAMPLING: begin
                if (settle_reg != '0) begin
                    settle_next = settle_reg - 8'd1;
                end else begin
                    step_next = acss_pkg::STEP_CONFIG;
                end
            end
            acss_pkg::STEP_CONFIG: begin
                tick.start_conversion = 1'b1;
                step_next             = acss_pkg::STEP_WAIT;
            end
            acss_pkg::STEP_WAIT: begin
                if (!converter_busy) begin
                    step_next = acss_pkg::STEP_READ;
                end
            end
            acss_pkg::STEP_READ: begin
                tick.write = advance
                    && ({1'b0, channel_reg} < acss_pkg::CntW'(acss_pkg::ChannelCount));
                step_next  = acss_pkg::STEP_INIT;
            end
            default: begin
                step_next = acss_pkg::STEP_INIT;
            end
        endcase
        tick.mux_select = channel_next;
    end

endmodule

/* sv/acss_result_store.sv */
// per-channel result store with query read and same-tick bypass
module acss_result_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acss_pkg::acss_tick_t          tick,
    input  logic                          eight_bit_mode,
    input  logic [acss_pkg::ByteW-1:0]    result_low_byte,
    input  logic [acss_pkg::ByteW-1:0]    result_high_byte,
    input  logic [acss_pkg::ChanW-1:0]    query_channel,
    output logic [acss_pkg::ValueW-1:0]   query_value
);

    logic [acss_pkg::ValueW-1:0] results_reg [acss_pkg::ChannelCount];
    logic [acss_pkg::ValueW-1:0] sample_value;
    logic                        query_in_range;

    // high byte alone or high:low word
    assign sample_value = eight_bit_mode ? {8'h00, result_high_byte}
                                         : {result_high_byte, result_low_byte};

    // store, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < acss_pkg::ChannelCount; i++) begin
                results_reg[i] <= '0;
            end
        end else if (tick.write) begin
            results_reg[tick.channel] <= sample_value;
        end
    end

    // query read, a value stored this tick is visible
    always_comb begin
        query_in_range = {1'b0, query_channel} < acss_pkg::CntW'(acss_pkg::ChannelCount);
        if (!query_in_range) begin
            query_value = '0;
        end else if (tick.write && (tick.channel == query_channel)) begin
            query_value = sample_value;
        end else begin
            query_value = results_reg[query_channel];
        end
    end

endmodule

/* sv/acss_checker.sv */
// port-level checks of the scan sequencer result channel
`include "adc_channel_scan_sequencer_core_assert.svh"

module acss_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_start_conversion,
    input logic [acss_pkg::ChanW-1:0] m_mux_select,
    input logic                       m_sample_stored
);

    // a stalled word holds
    `ACSS_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_mux_select))

    // mux select never names a channel that does not exist
    `ACSS_ASSERT_NOW(a_mux_range, m_valid, m_mux_select <= 3'(acss_pkg::ChannelCount - 1))

    // start and store come from different scan steps
    `ACSS_ASSERT_NOW(a_start_store_excl, m_valid, !(m_start_conversion && m_sample_stored))

    // a conversion start is never followed directly by another
    `ACSS_ASSERT_NEXT(a_start_single, m_valid && m_ready && m_start_conversion,
        !(m_valid && m_start_conversion))

endmodule

bind adc_channel_scan_sequencer_core acss_checker u_acss_checker (.*);
